// File: hw/rtl/conv3x3_zero_pad_filter_assert.svh
// Assertion macros shared by the 3x3 filter RTL
`ifndef CONV3X3_ZERO_PAD_FILTER_ASSERT_SVH
`define CONV3X3_ZERO_PAD_FILTER_ASSERT_SVH

// Condition must hold in the same cycle as the trigger
`define C3ZP_ASSERT_HOLDS(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("c3zp: same-cycle check failed");

// Condition must hold in the cycle after the trigger
`define C3ZP_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("c3zp: next-cycle check failed");

`endif

// File: hw/rtl/c3zp_pkg.sv
// Shared types and constants of the 3x3 zero-padded filter
package c3zp_pkg;

    localparam int PIX_W        = 8;
    localparam int DIM_CFG_W    = 11;
    localparam int COEF_FIELD_W = 16;
    localparam int CFG_DATA_W   = 48;
    localparam int CFG_IDX_W    = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_ROW_TOP    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_ROW_MID    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_ROW_BOTTOM = 3'd4;

    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_FLUSH = 1'b1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    // Per-command control from the front to the back
    typedef struct packed {
        logic emit;
        logic last;
        logic top_ok;
        logic bot_ok;
        logic left_ok;
        logic right_ok;
    } cmd_ctl_t;

endpackage

// File: hw/rtl/c3zp_front.sv
// Front end: accepts pixels and flushes, tracks frame position, issues shift commands
`include "conv3x3_zero_pad_filter_assert.svh"

module c3zp_front
    import c3zp_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [PIX_W-1:0]              s_tdata,   // [7:0] pixel
    input  logic                          s_tuser,   // [0] req_type
    input  logic [DIM_CFG_W-1:0]          image_width,
    input  logic [DIM_CFG_W-1:0]          image_height,
    input  logic                          q_full,
    output logic                          push,
    output cmd_ctl_t                      cmd_ctl,
    output logic [PIX_W-1:0]              cmd_pixel,
    output logic [$clog2(MAX_WIDTH)-1:0]  cmd_ptr
);

    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int HW  = $clog2(MAX_HEIGHT + 1);
    localparam int CLW = $clog2(MAX_WIDTH);
    localparam int ORW = $clog2(MAX_HEIGHT);
    localparam int CWW = (WW > DIM_CFG_W) ? WW : DIM_CFG_W;
    localparam int CWH = (HW > DIM_CFG_W) ? HW : DIM_CFG_W;
    localparam logic [WW-1:0] W_RST = WW'((MAX_WIDTH < 1024) ? MAX_WIDTH : 1024);
    localparam logic [HW-1:0] H_RST = HW'((MAX_HEIGHT < 1024) ? MAX_HEIGHT : 1024);

    logic [CLW-1:0] in_col_reg, in_col_next;
    logic [HW-1:0]  in_row_reg, in_row_next;
    logic [CLW-1:0] out_col_reg, out_col_next;
    logic [ORW-1:0] out_row_reg, out_row_next;
    logic [WW-1:0]  frame_w_reg, frame_w_next;
    logic [HW-1:0]  frame_h_reg, frame_h_next;
    logic [CLW-1:0] ptr_reg, ptr_next;
    logic           extra_reg, extra_next;

    logic [WW-1:0]  clamp_w;
    logic [HW-1:0]  clamp_h;
    logic           first;
    logic [WW-1:0]  w_eff;
    logic [HW-1:0]  h_eff;
    logic           frame_done;
    logic           accept;
    logic           last_pos;
    cmd_ctl_t       emit_ctl;

    always_comb
    begin
        logic [CWW-1:0] vw;
        logic [CWH-1:0] vh;
        vw = CWW'(image_width);
        vh = CWH'(image_height);
        if (vw == '0)
            clamp_w = WW'(1);
        else if (vw > CWW'(MAX_WIDTH))
            clamp_w = WW'(MAX_WIDTH);
        else
            clamp_w = WW'(vw);
        if (vh == '0)
            clamp_h = HW'(1);
        else if (vh > CWH'(MAX_HEIGHT))
            clamp_h = HW'(MAX_HEIGHT);
        else
            clamp_h = HW'(vh);
    end

    assign first      = (in_row_reg == '0) && (in_col_reg == '0);
    assign w_eff      = first ? clamp_w : frame_w_reg;
    assign h_eff      = first ? clamp_h : frame_h_reg;
    assign frame_done = (in_row_reg >= frame_h_reg);
    assign s_tready   = !extra_reg && !q_full;
    assign accept     = s_tvalid && s_tready;

    // Position of the next result and its neighbour validity
    assign last_pos = (HW'(out_row_reg) == frame_h_reg - HW'(1))
                   && (WW'(out_col_reg) == frame_w_reg - WW'(1));

    always_comb
    begin
        emit_ctl.emit     = 1'b1;
        emit_ctl.last     = last_pos;
        emit_ctl.top_ok   = (out_row_reg != '0);
        emit_ctl.bot_ok   = (HW'(out_row_reg) != frame_h_reg - HW'(1));
        emit_ctl.left_ok  = (out_col_reg != '0);
        emit_ctl.right_ok = (WW'(out_col_reg) != frame_w_reg - WW'(1));
    end

    always_comb
    begin
        logic [CLW-1:0] ptr_cur;
        logic           emit_pix;
        logic           do_emit;
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        frame_w_next = frame_w_reg;
        frame_h_next = frame_h_reg;
        ptr_next     = ptr_reg;
        extra_next   = extra_reg;
        push         = 1'b0;
        cmd_ctl      = '0;
        cmd_pixel    = '0;
        ptr_cur      = ptr_reg;
        do_emit      = 1'b0;
        emit_pix     = (in_row_reg >= HW'(2))
                    || ((in_row_reg == HW'(1)) && (in_col_reg != '0));

        if (extra_reg)
        begin
            // One zero shift so a single-row frame lines up with its flushes
            if (!q_full)
            begin
                push       = 1'b1;
                extra_next = 1'b0;
            end
        end
        else if (accept)
        begin
            case (s_tuser)
                REQ_FLUSH:
                begin
                    if (frame_done)
                    begin
                        push    = 1'b1;
                        do_emit = 1'b1;
                    end
                end
                REQ_PIXEL:
                begin
                    if (!frame_done)
                    begin
                        push      = 1'b1;
                        cmd_pixel = s_tdata;
                        if (first)
                        begin
                            frame_w_next = clamp_w;
                            frame_h_next = clamp_h;
                            ptr_cur      = '0;
                        end
                        if (WW'(in_col_reg) == w_eff - WW'(1))
                        begin
                            in_col_next = '0;
                            in_row_next = in_row_reg + HW'(1);
                            if ((in_row_reg + HW'(1) == h_eff) && (h_eff == HW'(1)))
                                extra_next = 1'b1;
                        end
                        else
                        begin
                            in_col_next = in_col_reg + CLW'(1);
                        end
                        do_emit = emit_pix;
                    end
                end
                default:
                begin
                end
            endcase
        end

        cmd_ptr = ptr_cur;
        if (push)
        begin
            if (WW'(ptr_cur) == w_eff - WW'(1))
                ptr_next = '0;
            else
                ptr_next = ptr_cur + CLW'(1);
        end

        if (do_emit)
        begin
            cmd_ctl = emit_ctl;
            if (last_pos)
            begin
                // Frame complete: restart the input and output position counters
                in_col_next  = '0;
                in_row_next  = '0;
                out_col_next = '0;
                out_row_next = '0;
            end
            else if (WW'(out_col_reg) == frame_w_reg - WW'(1))
            begin
                out_col_next = '0;
                out_row_next = out_row_reg + ORW'(1);
            end
            else
            begin
                out_col_next = out_col_reg + CLW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            frame_w_reg <= W_RST;
            frame_h_reg <= H_RST;
            ptr_reg     <= '0;
            extra_reg   <= 1'b0;
        end
        else
        begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            frame_w_reg <= frame_w_next;
            frame_h_reg <= frame_h_next;
            ptr_reg     <= ptr_next;
            extra_reg   <= extra_next;
        end
    end

    `C3ZP_ASSERT_HOLDS(a_in_row_bound, 1'b1, in_row_reg <= frame_h_reg)
    `C3ZP_ASSERT_HOLDS(a_extra_single_row, extra_reg, (frame_h_reg == HW'(1)) && (in_row_reg == HW'(1)))
    `C3ZP_ASSERT_NEXT(a_last_restarts, push && cmd_ctl.last, (in_row_reg == '0) && (out_row_reg == '0) && (out_col_reg == '0))

endmodule

// File: hw/rtl/c3zp_queue.sv
// Short command queue between the front end and the filter back end
`include "conv3x3_zero_pad_filter_assert.svh"

module c3zp_queue
    import c3zp_pkg::*;
#(
    parameter int DATA_W = 24
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    input  logic              pop,
    output logic [DATA_W-1:0] head_data,
    output logic              empty,
    output logic              full
);

    logic [DATA_W-1:0] entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_pop;

    assign empty     = (count_reg == '0);
    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_data = entry_reg[rd_ptr_reg];
    assign do_pop    = pop && !empty;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !do_pop)
            count_next = count_reg + QCNT_W'(1);
        else if (!push && do_pop)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    `C3ZP_ASSERT_HOLDS(a_no_push_when_full, push, !full)

endmodule

// File: hw/rtl/c3zp_back.sv
// Back end: line stores, 3x3 window, multiply and sum, output register
module c3zp_back
    import c3zp_pkg::*;
#(
    parameter int MAX_WIDTH = 1024,
    parameter int COEF_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          head_valid,
    input  cmd_ctl_t                      head_ctl,
    input  logic [PIX_W-1:0]              head_pixel,
    input  logic [$clog2(MAX_WIDTH)-1:0]  head_ptr,
    output logic                          pop,
    input  logic [CFG_DATA_W-1:0]         coef_row_top,
    input  logic [CFG_DATA_W-1:0]         coef_row_mid,
    input  logic [CFG_DATA_W-1:0]         coef_row_bottom,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [PIX_W-1:0]              m_tdata,   // [7:0] filtered_pixel
    output logic                          m_tlast
);

    localparam int CLW = $clog2(MAX_WIDTH);

    logic [PIX_W-1:0] upper_mem [MAX_WIDTH];
    logic [PIX_W-1:0] lower_mem [MAX_WIDTH];

    logic             adv;
    logic             s1_valid_reg;
    cmd_ctl_t         s1_ctl_reg;
    logic [PIX_W-1:0] s1_pix_reg;
    logic [CLW-1:0]   s1_ptr_reg;
    logic [PIX_W-1:0] upper_rd_reg, lower_rd_reg;
    logic             fwd_reg;
    logic [PIX_W-1:0] fwd_upper_reg, fwd_lower_reg;
    logic [PIX_W-1:0] upper_val, lower_val;

    logic [PIX_W-1:0] win_reg  [3][3];
    logic [PIX_W-1:0] win_next [3][3];
    logic [CFG_DATA_W-1:0] coef_rows [3];
    logic [PIX_W-1:0] coef8     [3][3];
    logic [PIX_W-1:0] prod_next [3][3];
    logic [PIX_W-1:0] prod_reg  [3][3];
    logic             row_ok [3];
    logic             col_ok [3];

    logic             s2_valid_reg;
    logic             s2_last_reg;
    logic [PIX_W-1:0] sum;
    logic             out_valid_reg;
    logic [PIX_W-1:0] out_data_reg;
    logic             out_last_reg;

    // Whole pipeline advances together when the output register can move
    assign adv = !out_valid_reg || m_tready;
    assign pop = adv && head_valid;

    // Take the value being written in the same cycle as the read
    assign upper_val = fwd_reg ? fwd_upper_reg : upper_rd_reg;
    assign lower_val = fwd_reg ? fwd_lower_reg : lower_rd_reg;

    assign coef_rows[0] = coef_row_top;
    assign coef_rows[1] = coef_row_mid;
    assign coef_rows[2] = coef_row_bottom;

    // Only the low 8 bits of each sign-extended coefficient reach the result
    always_comb
    begin
        logic [COEF_FIELD_W-1:0] field;
        field = '0;
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                field = coef_rows[r][COEF_FIELD_W*c +: COEF_FIELD_W];
                for (int i = 0; i < PIX_W; i++)
                    coef8[r][c][i] = (i < COEF_BITS) ? field[i] : field[COEF_BITS-1];
            end
        end
    end

    always_comb
    begin
        win_next = win_reg;
        if (s1_valid_reg)
        begin
            for (int r = 0; r < 3; r++)
            begin
                win_next[r][0] = win_reg[r][1];
                win_next[r][1] = win_reg[r][2];
            end
            win_next[0][2] = upper_val;
            win_next[1][2] = lower_val;
            win_next[2][2] = s1_pix_reg;
        end
    end

    assign row_ok[0] = s1_ctl_reg.top_ok;
    assign row_ok[1] = 1'b1;
    assign row_ok[2] = s1_ctl_reg.bot_ok;
    assign col_ok[0] = s1_ctl_reg.left_ok;
    assign col_ok[1] = 1'b1;
    assign col_ok[2] = s1_ctl_reg.right_ok;

    always_comb
    begin
        logic [2*PIX_W-1:0] p16;
        p16 = '0;
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                p16 = {{PIX_W{1'b0}}, win_next[r][c]} * {{PIX_W{1'b0}}, coef8[r][c]};
                prod_next[r][c] = (row_ok[r] && col_ok[c]) ? p16[PIX_W-1:0] : '0;
            end
        end
    end

    assign sum = ((prod_reg[0][0] + prod_reg[0][1]) + (prod_reg[0][2] + prod_reg[1][0]))
               + ((prod_reg[1][1] + prod_reg[1][2]) + (prod_reg[2][0] + prod_reg[2][1]))
               + prod_reg[2][2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            fwd_reg       <= 1'b0;
            win_reg       <= '{default: '0};
        end
        else if (adv)
        begin
            s1_valid_reg  <= head_valid;
            s2_valid_reg  <= s1_valid_reg && s1_ctl_reg.emit;
            out_valid_reg <= s2_valid_reg;
            fwd_reg       <= s1_valid_reg && (s1_ptr_reg == head_ptr);
            if (s1_valid_reg)
                win_reg <= win_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_ctl_reg    <= head_ctl;
            s1_pix_reg    <= head_pixel;
            s1_ptr_reg    <= head_ptr;
            fwd_upper_reg <= lower_val;
            fwd_lower_reg <= s1_pix_reg;
            prod_reg      <= prod_next;
            s2_last_reg   <= s1_ctl_reg.last;
            out_data_reg  <= sum;
            out_last_reg  <= s2_last_reg;
        end
    end

    // Line stores: read at the head command, write from the stage after
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            upper_rd_reg <= upper_mem[head_ptr];
            lower_rd_reg <= lower_mem[head_ptr];
        end
        if (adv && s1_valid_reg)
        begin
            upper_mem[s1_ptr_reg] <= lower_val;
            lower_mem[s1_ptr_reg] <= s1_pix_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

// File: hw/rtl/conv3x3_zero_pad_filter.sv
// Top level of the 3x3 zero-padded convolution filter
//
// Streams an 8-bit grayscale frame in raster order and returns, for every
// pixel, the low 8 bits of the 3x3 neighbourhood weighted by nine signed
// coefficients, with neighbours outside the frame taken as zero. The result
// for a pixel leaves when the pixel one row and one column later is taken;
// after the last pixel, send flush transfers (tuser = 1) to drain the last
// row plus one results, and the final result of the frame carries tlast.
// One transfer is taken per clock while tready is high; each command
// goes through the line-store read, the window shift and multiply, then the
// sum into the output register; the two line stores have one read and one
// write port each, one access per pixel. A stalled output backs up the
// four-entry command queue, and tready drops once it is full. After the
// last pixel of a one-row frame, tready stays low while one extra zero
// command is pushed. Frame size is sampled on the first pixel of each
// frame; configuration writes are taken at any time with cfg_ready high.
module conv3x3_zero_pad_filter
    import c3zp_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int COEF_BITS  = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [PIX_W-1:0]      s_tdata,    // [7:0] pixel
    input  logic                  s_tuser,    // [0] req_type
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [PIX_W-1:0]      m_tdata,    // [7:0] filtered_pixel
    output logic                  m_tlast,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CLW = $clog2(MAX_WIDTH);
    localparam int Q_W = CLW + PIX_W + $bits(cmd_ctl_t);

    logic [DIM_CFG_W-1:0]  image_width_reg;
    logic [DIM_CFG_W-1:0]  image_height_reg;
    logic [CFG_DATA_W-1:0] coef_top_reg;
    logic [CFG_DATA_W-1:0] coef_mid_reg;
    logic [CFG_DATA_W-1:0] coef_bottom_reg;

    logic             q_push;
    logic             q_pop;
    logic             q_full;
    logic             q_empty;
    logic [Q_W-1:0]   q_head;
    cmd_ctl_t         cmd_ctl;
    logic [PIX_W-1:0] cmd_pixel;
    logic [CLW-1:0]   cmd_ptr;
    cmd_ctl_t         head_ctl;
    logic [PIX_W-1:0] head_pixel;
    logic [CLW-1:0]   head_ptr;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= DIM_CFG_W'(1024);
            image_height_reg <= DIM_CFG_W'(1024);
            coef_top_reg     <= '0;
            coef_mid_reg     <= '0;
            coef_bottom_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_IMAGE_WIDTH:     image_width_reg  <= cfg_data[DIM_CFG_W-1:0];
                CFG_IMAGE_HEIGHT:    image_height_reg <= cfg_data[DIM_CFG_W-1:0];
                CFG_COEF_ROW_TOP:    coef_top_reg     <= cfg_data;
                CFG_COEF_ROW_MID:    coef_mid_reg     <= cfg_data;
                CFG_COEF_ROW_BOTTOM: coef_bottom_reg  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    c3zp_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .image_width  (image_width_reg),
        .image_height (image_height_reg),
        .q_full       (q_full),
        .push         (q_push),
        .cmd_ctl      (cmd_ctl),
        .cmd_pixel    (cmd_pixel),
        .cmd_ptr      (cmd_ptr)
    );

    c3zp_queue #(
        .DATA_W (Q_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data ({cmd_ptr, cmd_pixel, cmd_ctl}),
        .pop       (q_pop),
        .head_data (q_head),
        .empty     (q_empty),
        .full      (q_full)
    );

    assign {head_ptr, head_pixel, head_ctl} = q_head;

    c3zp_back #(
        .MAX_WIDTH (MAX_WIDTH),
        .COEF_BITS (COEF_BITS)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .head_valid      (!q_empty),
        .head_ctl        (head_ctl),
        .head_pixel      (head_pixel),
        .head_ptr        (head_ptr),
        .pop             (q_pop),
        .coef_row_top    (coef_top_reg),
        .coef_row_mid    (coef_mid_reg),
        .coef_row_bottom (coef_bottom_reg),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tlast         (m_tlast)
    );

endmodule

// File: tb/conv3x3_zero_pad_filter_tb.sv
// Self-checking testbench for the 3x3 zero-padded convolution filter
module conv3x3_zero_pad_filter_tb;
    import c3zp_pkg::*;

    localparam int MAX_DIM         = 1024;
    localparam int RING_LEN        = 2 * MAX_DIM + 3;
    localparam int RANDOM_ITEMS    = 880;
    localparam int DRAIN_LIMIT     = 200000;
    localparam int PRESSURE_CYCLES = 400;
    localparam int PHASE_SETTLE    = 16;
    localparam int END_SETTLE      = 32;

    // RX_SLOW: sender gaps 12%, receiver stalls 68%; TX_SLOW the other way round
    typedef enum logic [1:0] {RX_SLOW, TX_SLOW, NO_GAPS} gap_mode_t;

    typedef struct {
        logic             req;
        logic [PIX_W-1:0] pix;
    } stream_item_t;

    typedef struct {
        logic [PIX_W-1:0] value;
        logic             last;
    } filtered_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [PIX_W-1:0]      s_tdata   = '0;    // [7:0] pixel
    logic                  s_tuser   = 1'b0;  // [0] req_type
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [PIX_W-1:0]      m_tdata;           // [7:0] filtered_pixel
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    stream_item_t pixels_to_send[$];
    filtered_t    filtered_due[$];
    gap_mode_t    gap_mode     = RX_SLOW;
    logic         s_took       = 1'b0;
    logic         hold_armed   = 1'b0;
    logic         hold_spent   = 1'b0;
    int           hold_left    = 0;
    int           items_queued = 0;
    int           fail_count   = 0;

    // Filter state as the predictor sees it
    logic [PIX_W-1:0]     seen_pixels[RING_LEN];
    logic [DIM_CFG_W-1:0] width_reg  = 11'd1024;
    logic [DIM_CFG_W-1:0] height_reg = 11'd1024;
    logic [CFG_DATA_W-1:0] coef_rows[3];
    int unsigned frame_w = MAX_DIM, frame_h = MAX_DIM;
    int unsigned in_col = 0, in_row = 0, out_col = 0, out_row = 0;

    conv3x3_zero_pad_filter i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever
        begin
            #2 clk = ~clk;
        end
    end

    initial
    begin
        #2000000;
        $display("status: fail");
        $finish;
    end

    function automatic int unsigned clamp_size(logic [DIM_CFG_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > MAX_DIM)
            return MAX_DIM;
        return 32'(v);
    endfunction

    function automatic logic [PIX_W-1:0] pixel_at(int r, int c);
        if (r < 0 || c < 0 || r >= int'(frame_h) || c >= int'(frame_w))
            return '0;
        return seen_pixels[(r * int'(frame_w) + c) % RING_LEN];
    endfunction

    function automatic logic [PIX_W-1:0] weighted_sum(int r, int c);
        int                 acc;
        logic signed [15:0] k;
        acc = 0;
        for (int dr = 0; dr < 3; dr++)
        begin
            for (int dc = 0; dc < 3; dc++)
            begin
                k = coef_rows[dr][COEF_FIELD_W*dc +: COEF_FIELD_W];
                acc += int'(pixel_at(r + dr - 1, c + dc - 1)) * int'(k);
            end
        end
        // keep the low byte only, the sum wraps
        return acc[PIX_W-1:0];
    endfunction

    function automatic void emit_filtered();
        filtered_t res;
        res.last  = (out_row == frame_h - 1) && (out_col == frame_w - 1);
        res.value = weighted_sum(int'(out_row), int'(out_col));
        filtered_due.push_back(res);
        out_col++;
        if (out_col >= frame_w)
        begin
            out_col = 0;
            out_row++;
        end
        if (res.last)
        begin
            in_col  = 0;
            in_row  = 0;
            out_col = 0;
            out_row = 0;
        end
    endfunction

    function automatic void take_item(logic req, logic [PIX_W-1:0] pix);
        int unsigned p;
        if (req == REQ_FLUSH)
        begin
            if (in_row >= frame_h)
                emit_filtered();
            return;
        end
        // drop pixels while the previous frame is still draining
        if (in_row >= frame_h)
            return;
        if (in_row == 0 && in_col == 0)
        begin
            frame_w = clamp_size(width_reg);
            frame_h = clamp_size(height_reg);
        end
        p = in_row * frame_w + in_col;
        seen_pixels[p % RING_LEN] = pix;
        in_col++;
        if (in_col >= frame_w)
        begin
            in_col = 0;
            in_row++;
        end
        if (p >= frame_w + 1)
            emit_filtered();
    endfunction

    function automatic logic roll(int pct);
        return $urandom_range(99) < pct;
    endfunction

    // Input side: drive at the falling edge, take transfers at the rising edge
    always @(negedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (!s_tvalid || s_took)
        begin
            if (pixels_to_send.size() != 0 &&
                !roll(gap_mode == RX_SLOW ? 12 : gap_mode == TX_SLOW ? 68 : 0))
            begin
                s_tvalid <= 1'b1;
                s_tuser  <= pixels_to_send[0].req;
                s_tdata  <= pixels_to_send[0].pix;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        stream_item_t item;
        if (rst_n && s_tvalid && s_tready)
        begin
            item = pixels_to_send.pop_front();
            take_item(item.req, item.pix);
            s_took = 1'b1;
        end
        else
            s_took = 1'b0;
    end

    // Output side: hold off once for a long stretch so the input backs up
    always @(negedge clk)
    begin
        if (hold_left != 0)
        begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end
        else if (hold_armed && !hold_spent)
        begin
            hold_spent = 1'b1;
            hold_left  = PRESSURE_CYCLES;
            m_tready <= 1'b0;
        end
        else
            m_tready <= !roll(gap_mode == RX_SLOW ? 68 : gap_mode == TX_SLOW ? 12 : 0);
    end

    always @(posedge clk)
    begin
        filtered_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (filtered_due.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, actual pixel %0d last %0b",
                         $time, m_tdata, m_tlast);
                fail_count++;
            end
            else
            begin
                want = filtered_due.pop_front();
                if (m_tdata !== want.value)
                begin
                    $display("%0t: filtered_pixel mismatch: expected %0d, actual %0d",
                             $time, want.value, m_tdata);
                    fail_count++;
                end
                if (m_tlast !== want.last)
                begin
                    $display("%0t: last_of_frame mismatch: expected %0b, actual %0b",
                             $time, want.last, m_tlast);
                    fail_count++;
                end
            end
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_IMAGE_WIDTH:     width_reg    = val[DIM_CFG_W-1:0];
            CFG_IMAGE_HEIGHT:    height_reg   = val[DIM_CFG_W-1:0];
            CFG_COEF_ROW_TOP:    coef_rows[0] = val;
            CFG_COEF_ROW_MID:    coef_rows[1] = val;
            CFG_COEF_ROW_BOTTOM: coef_rows[2] = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_setup(int w, int h, logic [CFG_DATA_W-1:0] top,
                              logic [CFG_DATA_W-1:0] mid, logic [CFG_DATA_W-1:0] bot);
        write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'(w));
        write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'(h));
        write_reg(CFG_COEF_ROW_TOP, top);
        write_reg(CFG_COEF_ROW_MID, mid);
        write_reg(CFG_COEF_ROW_BOTTOM, bot);
    endtask

    // Wait until every item is taken and every result is back, then settle
    task automatic wait_drained(int settle);
        int n;
        n = 0;
        while ((pixels_to_send.size() != 0 || filtered_due.size() != 0) && n < DRAIN_LIMIT)
        begin
            @(negedge clk);
            n++;
        end
        if (filtered_due.size() != 0 || pixels_to_send.size() != 0)
        begin
            $display("%0t: stream stuck: expected %0d more results, actual none",
                     $time, filtered_due.size());
            fail_count++;
            filtered_due.delete();
        end
        repeat (settle) @(negedge clk);
    endtask

    function automatic void queue_item(logic req, logic [PIX_W-1:0] pix);
        stream_item_t item;
        item.req = req;
        item.pix = pix;
        pixels_to_send.push_back(item);
        items_queued++;
    endfunction

    function automatic logic [PIX_W-1:0] rand_pixel();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return PIX_W'($urandom_range(255));
        endcase
    endfunction

    function automatic void queue_pixels(int n);
        repeat (n) queue_item(REQ_PIXEL, rand_pixel());
    endfunction

    function automatic void queue_flushes(int n);
        repeat (n) queue_item(REQ_FLUSH, rand_pixel());
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand_coefs();
        logic [CFG_DATA_W-1:0] v;
        for (int k = 0; k < 3; k++)
        begin
            case ($urandom_range(7))
                0:       v[16*k +: 16] = 16'h8000;
                1:       v[16*k +: 16] = 16'h7FFF;
                2:       v[16*k +: 16] = 16'hFFFF;
                3:       v[16*k +: 16] = 16'h0000;
                4:       v[16*k +: 16] = 16'($urandom_range(16)) - 16'd8;
                default: v[16*k +: 16] = 16'($urandom_range(16'hFFFF));
            endcase
        end
        return v;
    endfunction

    initial
    begin
        int   wr, hr, fw, fh, npx, split, random_start;
        logic first;

        foreach (seen_pixels[i])
            seen_pixels[i] = '0;
        foreach (coef_rows[i])
            coef_rows[i] = '0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        repeat (4) @(negedge clk);

        // Directed: extreme pixels and coefficients, early flush, pixel while draining
        load_setup(3, 2, {16'h7FFF, 16'h8000, 16'hFFFF}, {16'h0001, 16'h0009, 16'h8000},
                   {16'hFFFF, 16'h7FFF, 16'h0000});
        queue_item(REQ_FLUSH, 8'hFF);
        queue_item(REQ_PIXEL, 8'h00);
        queue_item(REQ_PIXEL, 8'hFF);
        queue_item(REQ_PIXEL, 8'hFF);
        queue_item(REQ_PIXEL, 8'hFF);
        queue_item(REQ_PIXEL, 8'h00);
        queue_item(REQ_PIXEL, 8'h80);
        queue_item(REQ_PIXEL, 8'hFF);
        queue_flushes(4);
        wait_drained(PHASE_SETTLE);

        // Zero width acts as one; the whole frame comes out on flushes
        write_reg(CFG_IMAGE_WIDTH, '0);
        queue_item(REQ_PIXEL, 8'hFF);
        queue_item(REQ_PIXEL, 8'h01);
        queue_flushes(2);
        wait_drained(PHASE_SETTLE);

        // Size and coefficient writes in the middle of a frame
        load_setup(4, 3, rand_coefs(), rand_coefs(), rand_coefs());
        queue_pixels(5);
        wait_drained(PHASE_SETTLE);
        load_setup(2, 9, rand_coefs(), rand_coefs(), rand_coefs());
        queue_pixels(7);
        queue_flushes(6);

        // Random frames, mostly well formed
        random_start = items_queued;
        first = 1'b1;
        while (items_queued - random_start < RANDOM_ITEMS)
        begin
            gap_mode = (items_queued - random_start < RANDOM_ITEMS / 2) ? RX_SLOW : TX_SLOW;
            if (first || $urandom_range(2) != 0)
            begin
                case ($urandom_range(9))
                    0:       wr = 0;
                    1:       wr = $urandom_range(13, 40);
                    default: wr = $urandom_range(1, 12);
                endcase
                case ($urandom_range(9))
                    0:       hr = 0;
                    1:       hr = (wr > 12) ? $urandom_range(1, 4) : $urandom_range(9, 16);
                    default: hr = $urandom_range(1, 8);
                endcase
                wait_drained(PHASE_SETTLE);
                load_setup(wr, hr, rand_coefs(), rand_coefs(), rand_coefs());
                first = 1'b0;
            end
            fw  = clamp_size(width_reg);
            fh  = clamp_size(height_reg);
            npx = fw * fh;
            if ($urandom_range(9) == 0)
                queue_flushes($urandom_range(1, 2));
            if (npx > 2 && $urandom_range(5) == 0)
            begin
                split = $urandom_range(1, npx - 1);
                queue_pixels(split);
                wait_drained(PHASE_SETTLE);
                write_reg(CFG_COEF_ROW_TOP, rand_coefs());
                write_reg(CFG_COEF_ROW_MID, rand_coefs());
                write_reg(CFG_COEF_ROW_BOTTOM, rand_coefs());
                if ($urandom_range(1) == 0)
                begin
                    write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'($urandom_range(1, 12)));
                    write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'($urandom_range(1, 8)));
                end
                queue_pixels(npx - split);
            end
            else
                queue_pixels(npx);
            if ($urandom_range(7) == 0)
                queue_item(REQ_PIXEL, rand_pixel());
            queue_flushes(fw + 1);
        end

        // Back-pressure: stall the output long enough to fill the block
        wait_drained(PHASE_SETTLE);
        gap_mode = NO_GAPS;
        load_setup(16, 10, rand_coefs(), rand_coefs(), rand_coefs());
        hold_armed = 1'b1;
        queue_pixels(160);
        queue_flushes(17);

        wait_drained(END_SETTLE);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
